[src/osp_pkg.sv]
// ----------------------------------------------------------------------------
// osp_pkg
// Types and constants shared by the point-to-screen transform pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package osp_pkg;

  // Coordinate format: signed, FRAC_BITS fraction bits
  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 8;

  // Gain format: signed Q16.16
  localparam int GAIN_WIDTH  = 32;
  localparam int GAIN_FRAC   = 16;

  localparam int CFG_WIDTH   = 32;
  localparam int CFG_IDX_W   = 3;
  localparam int SCR_WIDTH   = 32;
  localparam int ORG_WIDTH   = 32;
  localparam int RM_WIDTH    = 3;

  localparam int NUM_STAGES  = 5;

  // Datapath widths
  localparam int TOTAL_FRAC  = FRAC_BITS + GAIN_FRAC;
  localparam int PT_W        = COORD_WIDTH + 1;           // after one negation
  localparam int PROD_W      = PT_W + GAIN_WIDTH;         // exact product
  localparam int ORG_SH_W    = ORG_WIDTH + GAIN_FRAC;
  localparam int SUM_W       = ((PROD_W > ORG_SH_W) ? PROD_W : ORG_SH_W) + 1;
  localparam int RND_W       = SUM_W - TOTAL_FRAC;
  localparam int FIN_W       = ((RND_W > SCR_WIDTH) ? RND_W : SCR_WIDTH) + 2;

  // Rounding addends: half for positive values, half minus one for negative
  localparam logic [SUM_W-1:0] RND_HALF =
    {{(SUM_W-TOTAL_FRAC){1'b0}}, 1'b1, {(TOTAL_FRAC-1){1'b0}}};
  localparam logic [SUM_W-1:0] RND_HALF_M1 =
    {{(SUM_W-TOTAL_FRAC+1){1'b0}}, {(TOTAL_FRAC-1){1'b1}}};

  localparam logic [SCR_WIDTH-1:0] SCR_MAX = {1'b0, {(SCR_WIDTH-1){1'b1}}};
  localparam logic [SCR_WIDTH-1:0] SCR_MIN = {1'b1, {(SCR_WIDTH-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROT_MIRROR = 3'd0,
    REG_GAIN_X     = 3'd1,
    REG_GAIN_Y     = 3'd2,
    REG_ORIGIN_X   = 3'd3,
    REG_ORIGIN_Y   = 3'd4,
    REG_Y_UP       = 3'd5,
    REG_OFFSET_X   = 3'd6,
    REG_OFFSET_Y   = 3'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ORIENT_UP    = 2'd0,
    ORIENT_DOWN  = 2'd1,
    ORIENT_LEFT  = 2'd2,
    ORIENT_RIGHT = 2'd3
  } orient_e;

  localparam int MIRROR_BIT = 2;

  typedef struct packed {
    logic        [RM_WIDTH-1:0]   rotation_mirror;
    logic signed [GAIN_WIDTH-1:0] gain_x;
    logic signed [GAIN_WIDTH-1:0] gain_y;
    logic signed [ORG_WIDTH-1:0]  origin_x_scaled;
    logic signed [ORG_WIDTH-1:0]  origin_y_scaled;
    logic                         y_up;
    logic signed [SCR_WIDTH-1:0]  pixel_offset_x;
    logic signed [SCR_WIDTH-1:0]  pixel_offset_y;
  } cfg_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
  } point_t;

  typedef struct packed {
    logic signed [SCR_WIDTH-1:0] screen_x;
    logic signed [SCR_WIDTH-1:0] screen_y;
    logic                        clipped;
  } screen_t;

endpackage

`default_nettype wire

[src/orient_scale_point_to_screen_top.sv]
// ----------------------------------------------------------------------------
// orient_scale_point_to_screen_top
// Drawing point to screen pixel transform: orient, gain, origin, round,
// offset and saturate, five-stage pipeline.
// ----------------------------------------------------------------------------
//  channel  | signals                          | transfer
//  ---------+----------------------------------+---------------------------
//  in       | in_valid_i/in_ready_o/in_data_i  | valid & ready, point_t
//  out      | out_valid_o/out_ready_i/out_data_o | valid & ready, screen_t
//  cfg      | cfg_we_i/cfg_idx_i/cfg_data_i    | write on we, no wait
//
//  One point per cycle is sustained while out_ready_i stays high. The gain
//  multiply, origin subtract and rounding add each own a stage. Reset clears
//  the valid bits and loads register reset values. A stall on the output
//  holds only the stages that are full; a bubble further up is squeezed out,
//  and input is taken while a result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module orient_scale_point_to_screen_top (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire osp_pkg::point_t                in_data_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output osp_pkg::screen_t                    out_data_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [osp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [osp_pkg::CFG_WIDTH-1:0] cfg_data_i
);

  localparam int NS = osp_pkg::NUM_STAGES;

  osp_pkg::cfg_t cfg;
  logic [NS-1:0] valid_q, valid_d, en;
  logic signed [osp_pkg::PT_W-1:0]  ox, oy;
  logic signed [osp_pkg::RND_W-1:0] rx, ry;

  // A stage advances when it is empty or the stage after it advances
  always_comb begin
    en[NS-1] = !valid_q[NS-1] || out_ready_i;
    for (int s = NS - 2; s >= 0; s--) begin
      en[s] = !valid_q[s] || en[s+1];
    end
  end

  always_comb begin
    valid_d[0] = en[0] ? in_valid_i : valid_q[0];
    for (int s = 1; s < NS; s++) begin
      valid_d[s] = en[s] ? valid_q[s-1] : valid_q[s];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = valid_q[NS-1];

  osp_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  osp_orient u_orient (
    .clk_i             (clk_i),
    .en_i              (en[0]),
    .rotation_mirror_i (cfg.rotation_mirror),
    .point_i           (in_data_i),
    .x_o               (ox),
    .y_o               (oy)
  );

  osp_axis u_axis_x (
    .clk_i    (clk_i),
    .en_i     (en[3:1]),
    .point_i  (ox),
    .gain_i   (cfg.gain_x),
    .origin_i (cfg.origin_x_scaled),
    .rnd_o    (rx)
  );

  osp_axis u_axis_y (
    .clk_i    (clk_i),
    .en_i     (en[3:1]),
    .point_i  (oy),
    .gain_i   (cfg.gain_y),
    .origin_i (cfg.origin_y_scaled),
    .rnd_o    (ry)
  );

  osp_finish u_finish (
    .clk_i   (clk_i),
    .en_i    (en[4]),
    .cfg_i   (cfg),
    .rnd_x_i (rx),
    .rnd_y_i (ry),
    .res_o   (out_data_o)
  );

endmodule

`default_nettype wire

[src/osp_cfg.sv]
// ----------------------------------------------------------------------------
// osp_cfg
// Configuration register file with a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module osp_cfg (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [osp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [osp_pkg::CFG_WIDTH-1:0] cfg_data_i,
  output osp_pkg::cfg_t                       cfg_o
);

  osp_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rotation_mirror <= '0;
      cfg_q.gain_x          <= 32'sd65536;
      cfg_q.gain_y          <= 32'sd65536;
      cfg_q.origin_x_scaled <= -32'sd256;
      cfg_q.origin_y_scaled <= -32'sd256;
      cfg_q.y_up            <= 1'b0;
      cfg_q.pixel_offset_x  <= '0;
      cfg_q.pixel_offset_y  <= '0;
    end else if (cfg_we_i) begin
      unique case (osp_pkg::cfg_reg_e'(cfg_idx_i))
        osp_pkg::REG_ROT_MIRROR: cfg_q.rotation_mirror <= cfg_data_i[osp_pkg::RM_WIDTH-1:0];
        osp_pkg::REG_GAIN_X:     cfg_q.gain_x          <= cfg_data_i;
        osp_pkg::REG_GAIN_Y:     cfg_q.gain_y          <= cfg_data_i;
        osp_pkg::REG_ORIGIN_X:   cfg_q.origin_x_scaled <= cfg_data_i;
        osp_pkg::REG_ORIGIN_Y:   cfg_q.origin_y_scaled <= cfg_data_i;
        osp_pkg::REG_Y_UP:       cfg_q.y_up            <= cfg_data_i[0];
        osp_pkg::REG_OFFSET_X:   cfg_q.pixel_offset_x  <= cfg_data_i;
        osp_pkg::REG_OFFSET_Y:   cfg_q.pixel_offset_y  <= cfg_data_i;
        default:                 cfg_q.y_up            <= cfg_q.y_up;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

[src/osp_orient.sv]
// ----------------------------------------------------------------------------
// osp_orient
// Stage 1: mirror in x and turn the point by one of four orientations.
// ----------------------------------------------------------------------------
`default_nettype none

module osp_orient (
  input  wire logic                              clk_i,
  input  wire logic                              en_i,
  input  wire logic [osp_pkg::RM_WIDTH-1:0]     rotation_mirror_i,
  input  wire osp_pkg::point_t                   point_i,
  output logic signed [osp_pkg::PT_W-1:0]        x_o,
  output logic signed [osp_pkg::PT_W-1:0]        y_o
);

  logic signed [osp_pkg::PT_W-1:0] x_ext, y_ext, x_mir;
  logic signed [osp_pkg::PT_W-1:0] x_d, y_d, x_q, y_q;

  // One extra bit keeps the negation of the most negative point exact
  assign x_ext = osp_pkg::PT_W'(point_i.point_x);
  assign y_ext = osp_pkg::PT_W'(point_i.point_y);
  assign x_mir = rotation_mirror_i[osp_pkg::MIRROR_BIT] ? -x_ext : x_ext;

  always_comb begin
    unique case (osp_pkg::orient_e'(rotation_mirror_i[1:0]))
      osp_pkg::ORIENT_UP: begin
        x_d = x_mir;
        y_d = y_ext;
      end
      osp_pkg::ORIENT_DOWN: begin
        x_d = x_mir;
        y_d = -y_ext;
      end
      osp_pkg::ORIENT_LEFT: begin
        x_d = y_ext;
        y_d = x_mir;
      end
      osp_pkg::ORIENT_RIGHT: begin
        x_d = -y_ext;
        y_d = x_mir;
      end
      default: begin
        x_d = x_mir;
        y_d = y_ext;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
      y_q <= y_d;
    end
  end

  assign x_o = x_q;
  assign y_o = y_q;

endmodule

`default_nettype wire

[src/osp_axis.sv]
// ----------------------------------------------------------------------------
// osp_axis
// Stages 2-4 of one axis: gain multiply, origin subtract, round half away
// from zero.
// ----------------------------------------------------------------------------
`default_nettype none

module osp_axis (
  input  wire logic                                clk_i,
  input  wire logic [2:0]                          en_i,
  input  wire logic signed [osp_pkg::PT_W-1:0]     point_i,
  input  wire logic signed [osp_pkg::GAIN_WIDTH-1:0] gain_i,
  input  wire logic signed [osp_pkg::ORG_WIDTH-1:0]  origin_i,
  output logic signed [osp_pkg::RND_W-1:0]         rnd_o
);

  logic signed [osp_pkg::PROD_W-1:0]   prod_d, prod_q;
  logic signed [osp_pkg::ORG_SH_W-1:0] org_sh;
  logic signed [osp_pkg::SUM_W-1:0]    diff_d, diff_q;
  logic        [osp_pkg::SUM_W-1:0]    sum_r;
  logic signed [osp_pkg::RND_W-1:0]    rnd_q;

  // Exact signed product, FRAC_BITS + 16 fraction bits
  assign prod_d = osp_pkg::PROD_W'(point_i) * osp_pkg::PROD_W'(gain_i);

  // Align origin to the product's fraction
  assign org_sh = {origin_i, {osp_pkg::GAIN_FRAC{1'b0}}};
  assign diff_d = osp_pkg::SUM_W'(prod_q) - osp_pkg::SUM_W'(org_sh);

  // Negative values add half minus one so the floor shift rounds away from zero
  assign sum_r = diff_q + (diff_q[osp_pkg::SUM_W-1] ? osp_pkg::RND_HALF_M1
                                                     : osp_pkg::RND_HALF);

  always_ff @(posedge clk_i) begin
    if (en_i[0]) prod_q <= prod_d;
    if (en_i[1]) diff_q <= diff_d;
    if (en_i[2]) rnd_q  <= sum_r[osp_pkg::SUM_W-1:osp_pkg::TOTAL_FRAC];
  end

  assign rnd_o = rnd_q;

endmodule

`default_nettype wire

[src/osp_finish.sv]
// ----------------------------------------------------------------------------
// osp_finish
// Stage 5: y-up flip, pixel offset and saturation to 32 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module osp_finish (
  input  wire logic                              clk_i,
  input  wire logic                              en_i,
  input  wire osp_pkg::cfg_t                     cfg_i,
  input  wire logic signed [osp_pkg::RND_W-1:0]  rnd_x_i,
  input  wire logic signed [osp_pkg::RND_W-1:0]  rnd_y_i,
  output osp_pkg::screen_t                       res_o
);

  logic signed [osp_pkg::FIN_W-1:0] x_ext, y_ext, offx_ext, offy_ext, sum_x, sum_y;
  logic [osp_pkg::FIN_W-osp_pkg::SCR_WIDTH:0] hi_x, hi_y;
  logic ovf_x, ovf_y;
  osp_pkg::screen_t res_d, res_q;

  assign x_ext    = osp_pkg::FIN_W'(rnd_x_i);
  assign y_ext    = osp_pkg::FIN_W'(rnd_y_i);
  assign offx_ext = osp_pkg::FIN_W'(cfg_i.pixel_offset_x);
  assign offy_ext = osp_pkg::FIN_W'(cfg_i.pixel_offset_y);

  // y-up folds the negation into the offset add
  assign sum_x = offx_ext + x_ext;
  assign sum_y = cfg_i.y_up ? (offy_ext - y_ext) : (offy_ext + y_ext);

  // Overflow when the bits above the 32-bit sign differ
  assign hi_x  = sum_x[osp_pkg::FIN_W-1:osp_pkg::SCR_WIDTH-1];
  assign hi_y  = sum_y[osp_pkg::FIN_W-1:osp_pkg::SCR_WIDTH-1];
  assign ovf_x = !((&hi_x) || !(|hi_x));
  assign ovf_y = !((&hi_y) || !(|hi_y));

  always_comb begin
    res_d.screen_x = ovf_x ? (sum_x[osp_pkg::FIN_W-1] ? osp_pkg::SCR_MIN : osp_pkg::SCR_MAX)
                           : sum_x[osp_pkg::SCR_WIDTH-1:0];
    res_d.screen_y = ovf_y ? (sum_y[osp_pkg::FIN_W-1] ? osp_pkg::SCR_MIN : osp_pkg::SCR_MAX)
                           : sum_y[osp_pkg::SCR_WIDTH-1:0];
    res_d.clipped  = ovf_x | ovf_y;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) res_q <= res_d;
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

[sim/orient_scale_point_to_screen_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// orient_scale_point_to_screen_top_tb
// Drives drawing points into the point-to-screen transform and checks every
// screen point against a behavioral transform of its own: mirror, orient,
// gain, origin, round half away from zero, y-up, offset and saturation.
// Directed cases cover the extremes, rounding halves and all eight
// orientation codes; random phases run under varied register settings and
// random idling on both sides, plus one long output stall.
// ----------------------------------------------------------------------------

module orient_scale_point_to_screen_top_tb;

  localparam int CYCLE_LIMIT    = 500000;
  localparam int STALL_CYCLES   = 150;
  localparam int STALL_POINTS   = 60;
  localparam int RANDOM_PHASES  = 12;
  localparam int PHASE_POINTS   = 114;

  localparam int CW = osp_pkg::COORD_WIDTH;
  localparam int WW = osp_pkg::CFG_WIDTH;
  localparam int SW = osp_pkg::SCR_WIDTH;

  localparam logic signed [CW-1:0] PT_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] PT_MIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [WW-1:0] W_MAX  = {1'b0, {(WW-1){1'b1}}};
  localparam logic signed [WW-1:0] W_MIN  = {1'b1, {(WW-1){1'b0}}};

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          in_valid_i = 1'b0;
  logic                          in_ready_o;
  osp_pkg::point_t               in_data_i = '0;
  logic                          out_valid_o;
  logic                          out_ready_i = 1'b0;
  osp_pkg::screen_t              out_data_o;
  logic                          cfg_we_i = 1'b0;
  logic [osp_pkg::CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [WW-1:0]                 cfg_data_i = '0;

  // Register contents as the block should hold them
  osp_pkg::cfg_t cfg_now = '{rotation_mirror: 3'd0, gain_x: 32'sd65536,
                             gain_y: 32'sd65536, origin_x_scaled: -32'sd256,
                             origin_y_scaled: -32'sd256, y_up: 1'b0,
                             pixel_offset_x: 32'sd0, pixel_offset_y: 32'sd0};

  osp_pkg::screen_t expected_screens[$];
  int unsigned mismatches       = 0;
  int unsigned points_sent      = 0;
  int unsigned results_checked  = 0;
  int unsigned settings_applied = 0;
  int unsigned cycle_count      = 0;
  int unsigned rx_wait          = 0;
  bit          tx_burst         = 1'b0;
  bit          rx_burst         = 1'b0;
  logic        hold_rx          = 1'b0;

  orient_scale_point_to_screen_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_screens.size());
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------- transform

  // Multiply by gain, subtract origin, round half away from zero
  function automatic logic signed [63:0] gain_and_round(logic signed [33:0] pt,
                                                        logic signed [31:0] gain,
                                                        logic signed [31:0] org);
    logic signed [127:0] pt_w, gain_w, org_w, acc;
    logic [127:0]        mag;
    pt_w   = 128'(pt);
    gain_w = 128'(gain);
    org_w  = 128'(org);
    acc    = pt_w * gain_w - (org_w <<< osp_pkg::GAIN_FRAC);
    mag    = (acc < 0) ? -acc : acc;
    mag    = (mag + (128'd1 << (osp_pkg::TOTAL_FRAC - 1))) >> osp_pkg::TOTAL_FRAC;
    return (acc < 0) ? -$signed(mag[63:0]) : $signed(mag[63:0]);
  endfunction

  // {clipped, value}
  function automatic logic [SW:0] clamp_pixel(logic signed [63:0] v);
    if (v > $signed(osp_pkg::SCR_MAX)) return {1'b1, osp_pkg::SCR_MAX};
    if (v < $signed(osp_pkg::SCR_MIN)) return {1'b1, osp_pkg::SCR_MIN};
    return {1'b0, v[SW-1:0]};
  endfunction

  function automatic osp_pkg::screen_t point_to_screen(osp_pkg::point_t p,
                                                       osp_pkg::cfg_t c);
    logic signed [33:0]    x, y, t;
    logic signed [63:0]    sx, sy;
    logic [SW:0]           px, py;
    osp_pkg::screen_t      s;
    x = 34'(p.point_x);
    y = 34'(p.point_y);
    if (c.rotation_mirror[osp_pkg::MIRROR_BIT]) x = -x;
    case (osp_pkg::orient_e'(c.rotation_mirror[1:0]))
      osp_pkg::ORIENT_DOWN: y = -y;
      osp_pkg::ORIENT_LEFT: begin
        t = x;
        x = y;
        y = t;
      end
      osp_pkg::ORIENT_RIGHT: begin
        t = x;
        x = -y;
        y = t;
      end
      default: ;
    endcase
    sx = gain_and_round(x, c.gain_x, c.origin_x_scaled);
    sy = gain_and_round(y, c.gain_y, c.origin_y_scaled);
    if (c.y_up) sy = -sy;
    px = clamp_pixel(sx + 64'(c.pixel_offset_x));
    py = clamp_pixel(sy + 64'(c.pixel_offset_y));
    s.screen_x = px[SW-1:0];
    s.screen_y = py[SW-1:0];
    s.clipped  = px[SW] | py[SW];
    return s;
  endfunction

  // ---------------------------------------------------------------- channels

  function automatic int unsigned draw_gap(bit burst);
    return burst ? 0 : $urandom_range(0, 12);
  endfunction

  task automatic report_mismatch(string what);
    mismatches++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  task automatic send_point(osp_pkg::point_t p);
    int unsigned gap;
    gap = draw_gap(tx_burst);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= p;
    do @(posedge clk_i); while (!in_ready_o);
    expected_screens.push_back(point_to_screen(p, cfg_now));
    points_sent++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : rx_pacing
    int unsigned w;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      rx_wait     <= 0;
    end else if (out_valid_o && out_ready_i) begin
      w = draw_gap(rx_burst);
      rx_wait     <= w;
      out_ready_i <= (w == 0) && !hold_rx;
    end else if (rx_wait > 0) begin
      rx_wait     <= rx_wait - 1;
      out_ready_i <= (rx_wait == 1) && !hold_rx;
    end else begin
      out_ready_i <= !hold_rx;
    end
  end

  always @(posedge clk_i) begin : result_check
    osp_pkg::screen_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_screens.size() == 0) begin
        report_mismatch($sformatf("unexpected result x=%0d y=%0d clipped=%0b",
                                  $signed(out_data_o.screen_x),
                                  $signed(out_data_o.screen_y), out_data_o.clipped));
      end else begin
        want = expected_screens.pop_front();
        results_checked++;
        if (out_data_o.screen_x !== want.screen_x)
          report_mismatch($sformatf("screen_x %0d, expected %0d",
                                    $signed(out_data_o.screen_x), $signed(want.screen_x)));
        if (out_data_o.screen_y !== want.screen_y)
          report_mismatch($sformatf("screen_y %0d, expected %0d",
                                    $signed(out_data_o.screen_y), $signed(want.screen_y)));
        if (out_data_o.clipped !== want.clipped)
          report_mismatch($sformatf("clipped %0b, expected %0b",
                                    out_data_o.clipped, want.clipped));
      end
    end
  end

  // ---------------------------------------------------------------- registers

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_screens.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_reg(osp_pkg::cfg_reg_e idx, logic [WW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      osp_pkg::REG_ROT_MIRROR: cfg_now.rotation_mirror = data[osp_pkg::RM_WIDTH-1:0];
      osp_pkg::REG_GAIN_X:     cfg_now.gain_x          = data;
      osp_pkg::REG_GAIN_Y:     cfg_now.gain_y          = data;
      osp_pkg::REG_ORIGIN_X:   cfg_now.origin_x_scaled = data;
      osp_pkg::REG_ORIGIN_Y:   cfg_now.origin_y_scaled = data;
      osp_pkg::REG_Y_UP:       cfg_now.y_up            = data[0];
      osp_pkg::REG_OFFSET_X:   cfg_now.pixel_offset_x  = data;
      osp_pkg::REG_OFFSET_Y:   cfg_now.pixel_offset_y  = data;
      default: ;
    endcase
  endtask

  // Unused high bits of the narrow registers carry random junk
  task automatic apply_setting(osp_pkg::cfg_t c);
    logic [WW-1:0] junk;
    wait_idle();
    junk = $urandom;
    junk[osp_pkg::RM_WIDTH-1:0] = c.rotation_mirror;
    write_reg(osp_pkg::REG_ROT_MIRROR, junk);
    write_reg(osp_pkg::REG_GAIN_X, c.gain_x);
    write_reg(osp_pkg::REG_GAIN_Y, c.gain_y);
    write_reg(osp_pkg::REG_ORIGIN_X, c.origin_x_scaled);
    write_reg(osp_pkg::REG_ORIGIN_Y, c.origin_y_scaled);
    junk = $urandom;
    junk[0] = c.y_up;
    write_reg(osp_pkg::REG_Y_UP, junk);
    write_reg(osp_pkg::REG_OFFSET_X, c.pixel_offset_x);
    write_reg(osp_pkg::REG_OFFSET_Y, c.pixel_offset_y);
    cfg_we_i <= 1'b0;
    settings_applied++;
  endtask

  function automatic osp_pkg::cfg_t unity_setting();
    return '{rotation_mirror: 3'd0, gain_x: 32'sd65536, gain_y: 32'sd65536,
             origin_x_scaled: 32'sd0, origin_y_scaled: 32'sd0, y_up: 1'b0,
             pixel_offset_x: 32'sd0, pixel_offset_y: 32'sd0};
  endfunction

  function automatic osp_pkg::cfg_t random_setting(int flavor);
    osp_pkg::cfg_t c;
    c.rotation_mirror = 3'($urandom_range(0, 7));
    c.y_up            = 1'($urandom_range(0, 1));
    case (flavor)
      1: begin
        c.gain_x          = $urandom;
        c.gain_y          = $urandom;
        c.origin_x_scaled = $urandom;
        c.origin_y_scaled = $urandom;
        c.pixel_offset_x  = $urandom;
        c.pixel_offset_y  = $urandom;
      end
      2: begin
        c.gain_x          = W_MAX;
        c.gain_y          = W_MAX;
        c.origin_x_scaled = W_MAX;
        c.origin_y_scaled = W_MAX;
        c.pixel_offset_x  = W_MAX;
        c.pixel_offset_y  = W_MAX;
      end
      3: begin
        c.gain_x          = W_MIN;
        c.gain_y          = W_MIN;
        c.origin_x_scaled = W_MIN;
        c.origin_y_scaled = W_MIN;
        c.pixel_offset_x  = W_MIN;
        c.pixel_offset_y  = W_MIN;
      end
      default: begin
        c.gain_x          = int'($urandom_range(0, 16 << 16)) - (8 << 16);
        c.gain_y          = int'($urandom_range(0, 16 << 16)) - (8 << 16);
        c.origin_x_scaled = int'($urandom_range(0, 2 << 20)) - (1 << 20);
        c.origin_y_scaled = int'($urandom_range(0, 2 << 20)) - (1 << 20);
        c.pixel_offset_x  = int'($urandom_range(0, 8192)) - 4096;
        c.pixel_offset_y  = int'($urandom_range(0, 8192)) - 4096;
      end
    endcase
    return c;
  endfunction

  function automatic logic signed [CW-1:0] random_coord();
    logic signed [CW-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom;
      4, 5, 6:    v = int'($urandom_range(0, 1 << 17)) - (1 << 16);
      7: begin
        case ($urandom_range(0, 4))
          0:       v = PT_MIN;
          1:       v = PT_MAX;
          2:       v = 0;
          3:       v = -1;
          default: v = 1;
        endcase
      end
      // near a half pixel
      default: v = (int'($urandom_range(0, 2000)) - 1000) * 256 + 128
                   + int'($urandom_range(0, 2)) - 1;
    endcase
    return v;
  endfunction

  function automatic osp_pkg::point_t random_point();
    osp_pkg::point_t p;
    p.point_x = random_coord();
    p.point_y = random_coord();
    return p;
  endfunction

  // ---------------------------------------------------------------- tests

  task automatic test_reset_values();
    send_point('{point_x: 0, point_y: 0});
    send_point('{point_x: 256, point_y: -256});
    send_point('{point_x: PT_MAX, point_y: PT_MIN});
    send_point('{point_x: PT_MIN, point_y: PT_MAX});
  endtask

  task automatic test_half_rounding();
    apply_setting(unity_setting());
    send_point('{point_x: 128, point_y: -128});
    send_point('{point_x: 384, point_y: -384});
    send_point('{point_x: 127, point_y: -129});
    send_point('{point_x: -1, point_y: 1});
  endtask

  task automatic test_orientations();
    osp_pkg::cfg_t c;
    for (int rm = 0; rm < 8; rm++) begin
      c = unity_setting();
      c.rotation_mirror = 3'(rm);
      c.gain_y          = 32'sd131072;
      c.origin_x_scaled = 32'sd512;
      c.origin_y_scaled = -32'sd768;
      c.y_up            = rm[1];
      apply_setting(c);
      send_point('{point_x: 32'sh0001_2345, point_y: -32'sh0000_789A});
    end
  endtask

  task automatic test_saturation();
    osp_pkg::cfg_t c;
    c = '{rotation_mirror: 3'd4, gain_x: W_MAX, gain_y: W_MAX, origin_x_scaled: W_MIN,
          origin_y_scaled: W_MIN, y_up: 1'b1, pixel_offset_x: W_MAX, pixel_offset_y: W_MAX};
    apply_setting(c);
    send_point('{point_x: PT_MIN, point_y: PT_MIN});
    send_point('{point_x: PT_MAX, point_y: PT_MAX});
    c = '{rotation_mirror: 3'(osp_pkg::ORIENT_RIGHT), gain_x: W_MIN, gain_y: W_MIN,
          origin_x_scaled: W_MAX, origin_y_scaled: W_MAX, y_up: 1'b0,
          pixel_offset_x: W_MIN, pixel_offset_y: W_MIN};
    apply_setting(c);
    send_point('{point_x: PT_MIN, point_y: PT_MAX});
    send_point('{point_x: PT_MAX, point_y: PT_MIN});
    // small point, offset alone pushes past the top
    c = unity_setting();
    c.pixel_offset_x = W_MAX;
    apply_setting(c);
    send_point('{point_x: 512, point_y: -512});
  endtask

  task automatic test_output_stall();
    apply_setting(random_setting(0));
    tx_burst = 1'b1;
    fork
      begin
        hold_rx <= 1'b1;
        repeat (STALL_CYCLES) @(posedge clk_i);
        hold_rx <= 1'b0;
      end
    join_none
    repeat (STALL_POINTS) send_point(random_point());
    wait_idle();
    tx_burst = 1'b0;
  endtask

  task automatic test_random_phases();
    int flavor;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      if (ph == 3)           flavor = 2;
      else if (ph == 7)      flavor = 3;
      else if (ph % 3 == 1)  flavor = 1;
      else                   flavor = 0;
      apply_setting(random_setting(flavor));
      tx_burst = (ph % 5 == 4);
      rx_burst = (ph % 5 == 4) || (ph % 6 == 2);
      repeat (PHASE_POINTS) send_point(random_point());
    end
    wait_idle();
    tx_burst = 1'b0;
    rx_burst = 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_values();
    test_half_rounding();
    test_orientations();
    test_saturation();
    test_output_stall();
    test_random_phases();

    wait_idle();
    repeat (osp_pkg::NUM_STAGES + 5) @(posedge clk_i);

    $display("Sent %0d drawing points under %0d register settings; %0d screen points checked.",
             points_sent, settings_applied, results_checked);
    $display("Included a %0d-cycle output stall and %0d mismatches.", STALL_CYCLES, mismatches);
    if (mismatches == 0 && expected_screens.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
